// ===== hw/rtl/i8080_instruction_stream_decoder_macros.svh =====
// Assertion macros for the instruction stream decoder RTL.
`ifndef I8080_INSTRUCTION_STREAM_DECODER_MACROS_SVH
`define I8080_INSTRUCTION_STREAM_DECODER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ISD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define ISD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/i8080_isd_pkg.sv =====
// Shared types, constants and opcode classification for the 8080 stream decoder.
package i8080_isd_pkg;

  // Queue between front and back
  localparam int QAddrW = 2;
  localparam int QDepth = 1 << QAddrW;
  localparam int QCntW  = QAddrW + 1;

  // Operand modes
  typedef enum logic [2:0] {
    MODE_IMPLIED = 3'd0,
    MODE_D8      = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_ADDR    = 3'd3,
    MODE_JUMP    = 3'd4,
    MODE_RESTART = 3'd5,
    MODE_RETURN  = 3'd6
  } mode_e;

  // Byte phase of the front end, one-hot
  typedef enum logic [2:0] {
    PH_OPCODE = 3'b001,
    PH_OPER1  = 3'b010,
    PH_OPER2  = 3'b100
  } phase_e;

  // Raw instruction handed from front to back
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  opcode;
    logic [15:0] operand;
    logic        trunc;
  } raw_item_t;

  // Fully decoded result
  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode_value;
    logic [15:0] operand_value;
    logic [1:0]  instr_length;
    logic [2:0]  operand_mode;
    logic        is_jump;
    logic        undefined_opcode;
    logic        truncated;
  } result_t;

  // Opcodes not defined on the 8080
  function automatic logic op_undefined(logic [7:0] op);
    logic u;
    if (op < 8'h40) begin
      u = (op[2:0] == 3'd0) && (op != 8'h00);
    end else begin
      u = op inside {8'hCB, 8'hD9, 8'hDD, 8'hED, 8'hFD};
    end
    return u;
  endfunction

  // Standard 8080 opcode table reduced to operand modes
  function automatic mode_e op_mode(logic [7:0] op);
    mode_e m;
    m = MODE_IMPLIED;
    if (op_undefined(op)) begin
      m = MODE_IMPLIED;
    end else if (op < 8'h40) begin
      if ((op & 8'hCF) == 8'h01) begin
        m = MODE_WORD;
      end else if (op inside {8'h22, 8'h2A, 8'h32, 8'h3A}) begin
        m = MODE_ADDR;
      end else if (op[2:0] == 3'd6) begin
        m = MODE_D8;
      end
    end else if (op >= 8'hC0) begin
      case (op[2:0])
        3'd0: m = MODE_RETURN;
        3'd1: m = (op == 8'hC9) ? MODE_RETURN : MODE_IMPLIED;
        3'd2: m = MODE_JUMP;
        3'd3: begin
          if (op == 8'hC3) begin
            m = MODE_JUMP;
          end else if (op == 8'hD3 || op == 8'hDB) begin
            m = MODE_D8;
          end else begin
            m = MODE_IMPLIED;
          end
        end
        3'd4: m = MODE_JUMP;
        3'd5: m = (op == 8'hCD) ? MODE_JUMP : MODE_IMPLIED;
        3'd6: m = MODE_D8;
        default: m = MODE_RESTART;
      endcase
    end
    return m;
  endfunction

  // Instruction length in bytes given by the mode
  function automatic logic [1:0] mode_len(mode_e m);
    logic [1:0] l;
    case (m)
      MODE_D8:   l = 2'd2;
      MODE_WORD: l = 2'd3;
      MODE_ADDR: l = 2'd3;
      MODE_JUMP: l = 2'd3;
      default:   l = 2'd1;
    endcase
    return l;
  endfunction

endpackage

// ===== hw/rtl/i8080_isd_front.sv =====
// Front end: accepts code bytes, tracks byte phase and assembles raw instructions.
module i8080_isd_front import i8080_isd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_base_i,
  input  logic        accept_i,
  input  logic [7:0]  code_byte_i,
  input  logic        last_byte_i,
  output logic        q_push_o,
  output raw_item_t   q_data_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  held_op_q, held_op_d;
  logic [7:0]  oper_lo_q, oper_lo_d;
  logic [15:0] start_q, start_d;
  logic [15:0] next_addr_q, next_addr_d;
  logic [15:0] base_q, base_d;
  logic        emit;
  raw_item_t   item;
  logic [1:0]  len;

  // Length of the instruction whose bytes are being gathered
  assign len = mode_len(op_mode((phase_q == PH_OPER1) ? held_op_q : code_byte_i));

  // Phase sequencing and instruction assembly
  always_comb begin
    phase_d     = phase_q;
    held_op_d   = held_op_q;
    oper_lo_d   = oper_lo_q;
    start_d     = start_q;
    next_addr_d = next_addr_q;
    base_d      = base_q;
    emit        = 1'b0;
    item        = '{addr: start_q, opcode: held_op_q, operand: 16'd0, trunc: 1'b0};
    if (cfg_we_i) begin
      base_d      = cfg_base_i;
      next_addr_d = cfg_base_i;
      phase_d     = PH_OPCODE;
    end else if (accept_i) begin
      case (phase_q)
        PH_OPER1: begin
          item.operand = {8'd0, code_byte_i};
          if (len == 2'd2 || last_byte_i) begin
            emit        = 1'b1;
            item.trunc  = (len != 2'd2);
            phase_d     = PH_OPCODE;
          end else begin
            oper_lo_d = code_byte_i;
            phase_d   = PH_OPER2;
          end
        end
        PH_OPER2: begin
          emit         = 1'b1;
          item.operand = {code_byte_i, oper_lo_q};
          phase_d      = PH_OPCODE;
        end
        default: begin
          start_d     = next_addr_q;
          held_op_d   = code_byte_i;
          item.addr   = next_addr_q;
          item.opcode = code_byte_i;
          if (len == 2'd1 || last_byte_i) begin
            emit       = 1'b1;
            item.trunc = (len != 2'd1);
            phase_d    = PH_OPCODE;
          end else begin
            phase_d = PH_OPER1;
          end
        end
      endcase
      next_addr_d = next_addr_q + 16'd1;
      // End of segment restarts the address count
      if (last_byte_i) begin
        phase_d     = PH_OPCODE;
        next_addr_d = base_q;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPCODE;
      next_addr_q <= 16'd0;
      base_q      <= 16'd0;
    end else begin
      phase_q     <= phase_d;
      next_addr_q <= next_addr_d;
      base_q      <= base_d;
    end
  end

  // Instruction payload
  always_ff @(posedge clk_i) begin
    held_op_q <= held_op_d;
    oper_lo_q <= oper_lo_d;
    start_q   <= start_d;
  end

  assign q_push_o = emit;
  assign q_data_o = item;

endmodule

// ===== hw/rtl/i8080_isd_fifo.sv =====
// Short queue decoupling the front end from the back end.
`include "i8080_instruction_stream_decoder_macros.svh"
module i8080_isd_fifo import i8080_isd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  raw_item_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output raw_item_t data_o,
  output logic      empty_o
);

  localparam logic [QCntW-1:0] FullCnt = QCntW'(QDepth);

  raw_item_t          mem_q [QDepth];
  logic [QAddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAddrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  `ISD_ASSERT(a_cnt_range, cnt_q <= FullCnt, "queue count out of range")
  `ISD_ASSERT_IMPL(a_no_overflow, push_i, !full_o, "push into full queue")
  `ISD_ASSERT_IMPL(a_no_underflow, pop_i, !empty_o, "pop from empty queue")
  `ISD_ASSERT(a_ptr_gap, (wr_ptr_q - rd_ptr_q) == cnt_q[QAddrW-1:0],
              "queue pointers disagree with count")

endmodule

// ===== hw/rtl/i8080_isd_back.sv =====
// Back end: classifies queued instructions and holds the result for the consumer.
module i8080_isd_back import i8080_isd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  raw_item_t q_data_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output result_t   res_o
);

  logic    out_vld_q;
  result_t res_q, res_d;
  mode_e   mode;

  // Load a new result when the output slot is free or being drained
  assign q_pop_o = !q_empty_i && (!out_vld_q || pop_i);

  // Classification of the queued instruction
  always_comb begin
    mode                   = op_mode(q_data_i.opcode);
    res_d.instr_address    = q_data_i.addr;
    res_d.opcode_value     = q_data_i.opcode;
    res_d.operand_value    = q_data_i.operand;
    res_d.instr_length     = mode_len(mode);
    res_d.operand_mode     = mode;
    res_d.is_jump          = (mode == MODE_JUMP);
    res_d.undefined_opcode = op_undefined(q_data_i.opcode);
    res_d.truncated        = q_data_i.trunc;
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (q_pop_o) begin
      out_vld_q <= 1'b1;
    end else if (pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  assign empty_o = !out_vld_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/i8080_instruction_stream_decoder.sv =====
// Top level of the 8080 instruction stream decoder.
// Throughput: one code byte per cycle; push is refused only while the 4-entry queue is full.
// Path: an instruction is written into the queue at the edge that takes its final byte;
// the output register is then loaded from the queue once the output slot is free or being drained.
// Reset: asynchronous active low; queue and output empty, byte phase at opcode,
// base address and next address 0. Configuration writes are ready while push is low.
module i8080_instruction_stream_decoder import i8080_isd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] base_address_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  code_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] instr_address_o,
  output logic [7:0]  opcode_value_o,
  output logic [15:0] operand_value_o,
  output logic [1:0]  instr_length_o,
  output logic [2:0]  operand_mode_o,
  output logic        is_jump_o,
  output logic        undefined_opcode_o,
  output logic        truncated_o
);

  logic      accept;
  logic      cfg_we;
  logic      q_push, q_pop, q_empty;
  raw_item_t q_wdata, q_rdata;
  result_t   res;

  // Configuration and code bytes never share an edge
  assign cfg_ready_o = !push;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = push && !full;

  // Front end
  i8080_isd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_base_i  (base_address_i),
    .accept_i    (accept),
    .code_byte_i (code_byte_i),
    .last_byte_i (last_byte_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // Decoupling queue
  i8080_isd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Back end
  i8080_isd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign instr_address_o    = res.instr_address;
  assign opcode_value_o     = res.opcode_value;
  assign operand_value_o    = res.operand_value;
  assign instr_length_o     = res.instr_length;
  assign operand_mode_o     = res.operand_mode;
  assign is_jump_o          = res.is_jump;
  assign undefined_opcode_o = res.undefined_opcode;
  assign truncated_o        = res.truncated;

endmodule
